>>> rtl/ring_queue_with_putback_core_assert.svh
// ----------------------------------------------------------------------------
// Ring queue assertion macros
// Shared concurrent assertion forms for the ring queue modules.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_PUTBACK_CORE_ASSERT_SVH
`define RING_QUEUE_WITH_PUTBACK_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define RQP_CHECK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define RQP_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rqp_pkg.sv
// ----------------------------------------------------------------------------
// Ring queue package
// Sizes, command codes and interface structs shared by the ring queue modules.
// ----------------------------------------------------------------------------
package rqp_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int MAX_BURST  = 16;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int BURST_W = $clog2(MAX_BURST + 1);
	localparam int CMD_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ     = 3'd0,
		CMD_DEQ     = 3'd1,
		CMD_BURST   = 3'd2,
		CMD_PUTBACK = 3'd3,
		CMD_QUERY   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic             apply;
		logic [CNT_W-1:0] capacity;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic empty;
	} status_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [IDX_W-1:0]      raddr;
	} mem_req_t;

endpackage

>>> rtl/ring_queue_with_putback_core.sv
// ----------------------------------------------------------------------------
// Ring queue with putback
// Circular word queue with enqueue, dequeue, burst dequeue, putback at head
// and occupancy query, over a configurable active capacity.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    cmd, item_in, burst_count
// out      source     out_valid / out_stall  accepted, item_out, last, delivered, occupancy
// cfg      sink       cfg_valid / cfg_ready  cfg_data (capacity)
//
// Enqueue, putback, query and refused commands: result presented in the cycle
// after the transaction is taken; next transaction taken once that result is taken.
// Dequeue and burst: each word goes through a read state, then an emit state,
// since the entry store has a registered read port.
// Reset leaves the queue empty with capacity 256; no clearing pass.
// A stalled result holds; in_stall stays high until the last result is taken.
// ----------------------------------------------------------------------------
module ring_queue_with_putback_core import rqp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [DATA_WIDTH-1:0] item_in,
	input  logic [BURST_W-1:0]    burst_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic [DATA_WIDTH-1:0] item_out,
	output logic                  last,
	output logic [BURST_W-1:0]    delivered,
	output logic [CNT_W-1:0]      occupancy
);

	logic [CNT_W-1:0]      capacity_q;
	cfg_t                  cfg;
	status_t               status;
	mem_req_t              mem_req;
	logic [DATA_WIDTH-1:0] mem_rdata;
	logic                  cfg_ok;

	assign cfg_ready    = status.idle && !in_valid;
	assign cfg_ok       = status.empty && (cfg_data != '0) && (cfg_data <= CNT_W'(DEPTH));
	assign cfg.apply    = cfg_valid && cfg_ready && cfg_ok;
	assign cfg.capacity = capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CNT_W'(DEPTH);
		end else if (cfg.apply) begin
			capacity_q <= cfg_data;
		end
	end

	rqp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.status      (status),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.item_in     (item_in),
		.burst_count (burst_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.item_out    (item_out),
		.last        (last),
		.delivered   (delivered),
		.occupancy   (occupancy),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	rqp_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

>>> rtl/rqp_store.sv
// ----------------------------------------------------------------------------
// Ring queue entry store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rqp_store import rqp_pkg::*; (
	input  logic                  clk,
	input  mem_req_t              req,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rqp_idx_unit.sv
// ----------------------------------------------------------------------------
// Ring queue index unit
// Shared wrap-around step of a queue index, forwards or backwards.
// ----------------------------------------------------------------------------
module rqp_idx_unit import rqp_pkg::*; (
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] capacity,
	input  logic             retreat,
	output logic [IDX_W-1:0] result
);

	logic [CNT_W-1:0] inc;
	logic [CNT_W-1:0] cap_m1;

	always_comb begin
		inc    = CNT_W'(idx) + CNT_W'(1);
		cap_m1 = capacity - CNT_W'(1);
		if (retreat) begin
			result = (idx == '0) ? cap_m1[IDX_W-1:0] : idx - IDX_W'(1);
		end else begin
			result = (inc >= capacity) ? '0 : inc[IDX_W-1:0];
		end
	end

endmodule

>>> rtl/rqp_seq.sv
// ----------------------------------------------------------------------------
// Ring queue sequencer
// Command decode, pointer and count state, burst stepping and result register.
// ----------------------------------------------------------------------------
`include "ring_queue_with_putback_core_assert.svh"

module rqp_seq import rqp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	output status_t               status,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [DATA_WIDTH-1:0] item_in,
	input  logic [BURST_W-1:0]    burst_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic [DATA_WIDTH-1:0] item_out,
	output logic                  last,
	output logic [BURST_W-1:0]    delivered,
	output logic [CNT_W-1:0]      occupancy,
	output mem_req_t              mem_req,
	input  logic [DATA_WIDTH-1:0] mem_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      tail_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [BURST_W-1:0]    rem_q;
	logic [BURST_W-1:0]    deliv_q;
	logic                  burst_q;
	logic                  accepted_q;
	logic [DATA_WIDTH-1:0] item_q;
	logic                  last_q;
	logic [BURST_W-1:0]    delivered_q;
	logic [CNT_W-1:0]      occ_q;

	logic                  take;
	logic                  full;
	logic                  empty;
	logic                  burst_ok;
	logic                  pop_next;
	logic [BURST_W-1:0]    want;
	logic [BURST_W-1:0]    first_n;
	logic [IDX_W-1:0]      idx_sel;
	logic                  retreat_sel;
	logic [IDX_W-1:0]      idx_next;

	rqp_idx_unit u_idx (
		.idx      (idx_sel),
		.capacity (cfg.capacity),
		.retreat  (retreat_sel),
		.result   (idx_next)
	);

	always_comb begin
		take     = in_valid && (state_q == ST_IDLE);
		full     = cnt_q >= cfg.capacity;
		empty    = cnt_q == '0;
		burst_ok = !empty && (burst_count != '0);
		pop_next = (state_q == ST_EMIT) && !out_stall && (rem_q != '0);
		want     = (burst_count > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : burst_count;
		first_n  = (CNT_W'(want) > cnt_q) ? cnt_q[BURST_W-1:0] : want;

		idx_sel       = head_q;
		retreat_sel   = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = tail_q;
		mem_req.wdata = item_in;
		mem_req.re    = pop_next;
		mem_req.raddr = head_q;
		if (take) begin
			unique case (cmd)
				CMD_ENQ: begin
					idx_sel    = tail_q;
					mem_req.we = !full;
				end
				CMD_DEQ: begin
					mem_req.re = !empty;
				end
				CMD_BURST: begin
					mem_req.re = burst_ok;
				end
				CMD_PUTBACK: begin
					retreat_sel   = 1'b1;
					mem_req.we    = !full;
					mem_req.waddr = idx_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			deliv_q     <= '0;
			burst_q     <= 1'b0;
			accepted_q  <= 1'b0;
			item_q      <= '0;
			last_q      <= 1'b0;
			delivered_q <= '0;
			occ_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						// refused result unless an arm below says otherwise
						accepted_q  <= 1'b0;
						item_q      <= '0;
						last_q      <= 1'b1;
						delivered_q <= '0;
						occ_q       <= cnt_q;
						state_q     <= ST_EMIT;
						unique case (cmd)
							CMD_ENQ: begin
								if (!full) begin
									tail_q     <= idx_next;
									cnt_q      <= cnt_q + CNT_W'(1);
									accepted_q <= 1'b1;
									occ_q      <= cnt_q + CNT_W'(1);
								end
							end
							CMD_DEQ: begin
								if (!empty) begin
									head_q  <= idx_next;
									cnt_q   <= cnt_q - CNT_W'(1);
									rem_q   <= BURST_W'(1);
									deliv_q <= '0;
									burst_q <= 1'b0;
									state_q <= ST_READ;
								end
							end
							CMD_BURST: begin
								if (burst_ok) begin
									head_q  <= idx_next;
									cnt_q   <= cnt_q - CNT_W'(1);
									rem_q   <= first_n;
									deliv_q <= '0;
									burst_q <= 1'b1;
									state_q <= ST_READ;
								end
							end
							CMD_PUTBACK: begin
								if (!full) begin
									head_q     <= idx_next;
									cnt_q      <= cnt_q + CNT_W'(1);
									accepted_q <= 1'b1;
									occ_q      <= cnt_q + CNT_W'(1);
								end
							end
							CMD_QUERY: begin
								accepted_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					accepted_q  <= 1'b1;
					item_q      <= mem_rdata;
					last_q      <= rem_q == BURST_W'(1);
					delivered_q <= burst_q ? deliv_q + BURST_W'(1) : '0;
					occ_q       <= cnt_q;
					rem_q       <= rem_q - BURST_W'(1);
					deliv_q     <= deliv_q + BURST_W'(1);
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (rem_q != '0) begin
							head_q  <= idx_next;
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg.apply) begin
				head_q <= '0;
				tail_q <= '0;
			end
		end
	end

	assign in_stall     = state_q != ST_IDLE;
	assign status.idle  = state_q == ST_IDLE;
	assign status.empty = empty;
	assign out_valid    = state_q == ST_EMIT;
	assign accepted     = accepted_q;
	assign item_out     = item_q;
	assign last         = last_q;
	assign delivered    = delivered_q;
	assign occupancy    = occ_q;

	`RQP_CHECK_ALWAYS(a_count_in_cap, cnt_q <= cfg.capacity, "held count above capacity")
	`RQP_CHECK_ALWAYS(a_head_in_cap, CNT_W'(head_q) < cfg.capacity, "head index beyond capacity")
	`RQP_CHECK_NEXT(a_read_emits, state_q == ST_READ, out_valid, "read word not presented")
	`RQP_CHECK_NEXT(a_last_ends, out_valid && !out_stall && last_q, !out_valid, "result after last")

endmodule
